// ===== hw/rtl/tilt_compensated_heading_top_defines.svh =====
// Assertion macros for the tilt-compensated heading block.
`ifndef TILT_COMPENSATED_HEADING_TOP_DEFINES_SVH
`define TILT_COMPENSATED_HEADING_TOP_DEFINES_SVH

// same-cycle implication
`define TCH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tch assertion failed");

// next-cycle implication
`define TCH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tch assertion failed");

`endif

// ===== hw/rtl/tch_pkg.sv =====
// Package: widths, register codes, CORDIC table and shared types.
`timescale 1ns / 1ps
package tch_pkg;

  localparam int CORDIC_STEPS_REQ = 16;
  localparam int TAB_LEN = 24;
  localparam int CORDIC_STEPS = (CORDIC_STEPS_REQ > TAB_LEN) ? TAB_LEN : CORDIC_STEPS_REQ;

  localparam int FIELD_W = 18;
  localparam int ANG_W   = 16;
  localparam int DIFF_W  = 19;
  localparam int SC_W    = 32;
  localparam int SCZ_W   = 33;
  localparam int TRIG_W  = SC_W - 14;
  localparam int PROD_W  = TRIG_W + DIFF_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int WL_W    = 19;
  localparam int SPW_W   = 57;
  localparam int VEC_W   = 58;
  localparam int IDX_W   = 2;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = 2;
  localparam int CNT_W = 3;

  localparam logic signed [SC_W-1:0] CORDIC_KQ30 = 32'sd652032874;
  localparam logic [31:0] HEADING_BIAS = 32'h4000_8000;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  localparam logic [IDX_W-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [IDX_W-1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [IDX_W-1:0] REG_OFFSET_Z = 2'd2;

  localparam logic signed [FIELD_W-1:0] OFFSET_X_RST = 18'sd2525;
  localparam logic signed [FIELD_W-1:0] OFFSET_Y_RST = 18'sd2889;
  localparam logic signed [FIELD_W-1:0] OFFSET_Z_RST = -18'sd1113;

  typedef struct packed {
    logic signed [DIFF_W-1:0] xx;
    logic signed [DIFF_W-1:0] yy;
    logic signed [DIFF_W-1:0] zz;
    logic [ANG_W-1:0]         roll;
    logic [ANG_W-1:0]         pitch;
  } item_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] count;
  } fifo_stat_t;

  function automatic logic [31:0] atan_tab(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/tch_front.sv =====
// Front end: offset registers, input handshake, hard-iron correction.
`timescale 1ns / 1ps
module tch_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tch_pkg::IDX_W-1:0]           cfg_idx_i,
  input  logic [tch_pkg::FIELD_W-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  input  logic signed [tch_pkg::FIELD_W-1:0]  field_x_i,
  input  logic signed [tch_pkg::FIELD_W-1:0]  field_y_i,
  input  logic signed [tch_pkg::FIELD_W-1:0]  field_z_i,
  input  logic signed [tch_pkg::ANG_W-1:0]    roll_angle_i,
  input  logic signed [tch_pkg::ANG_W-1:0]    pitch_angle_i,
  output logic                                in_stall_o,
  input  logic                                fifo_full_i,
  output logic                                push_o,
  output tch_pkg::item_t                      item_o
);

  logic signed [tch_pkg::FIELD_W-1:0] off_x_q, off_y_q, off_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= tch_pkg::OFFSET_X_RST;
      off_y_q <= tch_pkg::OFFSET_Y_RST;
      off_z_q <= tch_pkg::OFFSET_Z_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tch_pkg::REG_OFFSET_X: off_x_q <= cfg_wdata_i;
        tch_pkg::REG_OFFSET_Y: off_y_q <= cfg_wdata_i;
        tch_pkg::REG_OFFSET_Z: off_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  always_comb begin
    item_o.xx    = tch_pkg::DIFF_W'(field_x_i) - tch_pkg::DIFF_W'(off_x_q);
    item_o.yy    = tch_pkg::DIFF_W'(field_y_i) - tch_pkg::DIFF_W'(off_y_q);
    item_o.zz    = tch_pkg::DIFF_W'(field_z_i) - tch_pkg::DIFF_W'(off_z_q);
    item_o.roll  = roll_angle_i;
    item_o.pitch = pitch_angle_i;
  end

endmodule

// ===== hw/rtl/tch_fifo.sv =====
// Short item queue between front end and back end.
`timescale 1ns / 1ps
module tch_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tch_pkg::item_t      item_i,
  input  logic                pop_i,
  output tch_pkg::item_t      item_o,
  output tch_pkg::fifo_stat_t stat_o
);

  tch_pkg::item_t mem_q [tch_pkg::FIFO_DEPTH];
  logic [tch_pkg::PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [tch_pkg::CNT_W-1:0] count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  assign item_o       = mem_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == tch_pkg::CNT_W'(tch_pkg::FIFO_DEPTH));

endmodule

// ===== hw/rtl/tch_back.sv =====
// Back end: sin/cos CORDICs, tilt rotation, atan2 CORDIC, output register.
`timescale 1ns / 1ps
module tch_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tch_pkg::item_t                    item_i,
  input  logic                              item_valid_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [tch_pkg::ANG_W-1:0]  heading_o
);

  localparam int N   = tch_pkg::CORDIC_STEPS;
  localparam int LAT = 2 * N + 9;

  logic adv;
  logic [LAT-1:0] vld_q;

  assign adv   = !(vld_q[LAT-1] && out_stall_i);
  assign pop_o = adv && item_valid_i;

  // sin/cos rotation stages, roll (r) and pitch (p)
  logic signed [tch_pkg::SC_W-1:0]   rx_q [N+1], ry_q [N+1], px_q [N+1], py_q [N+1];
  logic signed [tch_pkg::SC_W-1:0]   rx_d [N+1], ry_d [N+1], px_d [N+1], py_d [N+1];
  logic signed [tch_pkg::SCZ_W-1:0]  rz_q [N+1], pz_q [N+1], rz_d [N+1], pz_d [N+1];
  logic                              rf_q [N+1], pf_q [N+1], rf_d [N+1], pf_d [N+1];
  logic signed [tch_pkg::DIFF_W-1:0] xx_q [N+1], yy_q [N+1], zz_q [N+1];
  logic signed [tch_pkg::DIFF_W-1:0] xx_d [N+1], yy_d [N+1], zz_d [N+1];

  logic [tch_pkg::ANG_W-1:0] ru, pu;

  always_comb begin
    rf_d[0] = item_i.roll[15] ^ item_i.roll[14];
    pf_d[0] = item_i.pitch[15] ^ item_i.pitch[14];
    ru = {item_i.roll[15] ^ rf_d[0], item_i.roll[14:0]};
    pu = {item_i.pitch[15] ^ pf_d[0], item_i.pitch[14:0]};
    rx_d[0] = tch_pkg::CORDIC_KQ30;
    ry_d[0] = '0;
    rz_d[0] = $signed({ru[15], ru, 16'h0000});
    px_d[0] = tch_pkg::CORDIC_KQ30;
    py_d[0] = '0;
    pz_d[0] = $signed({pu[15], pu, 16'h0000});
    xx_d[0] = item_i.xx;
    yy_d[0] = item_i.yy;
    zz_d[0] = item_i.zz;
    for (int k = 0; k < N; k++) begin
      if (!rz_q[k][tch_pkg::SCZ_W-1]) begin
        rx_d[k+1] = rx_q[k] - (ry_q[k] >>> k);
        ry_d[k+1] = ry_q[k] + (rx_q[k] >>> k);
        rz_d[k+1] = rz_q[k] - $signed({1'b0, tch_pkg::atan_tab(k)});
      end else begin
        rx_d[k+1] = rx_q[k] + (ry_q[k] >>> k);
        ry_d[k+1] = ry_q[k] - (rx_q[k] >>> k);
        rz_d[k+1] = rz_q[k] + $signed({1'b0, tch_pkg::atan_tab(k)});
      end
      if (!pz_q[k][tch_pkg::SCZ_W-1]) begin
        px_d[k+1] = px_q[k] - (py_q[k] >>> k);
        py_d[k+1] = py_q[k] + (px_q[k] >>> k);
        pz_d[k+1] = pz_q[k] - $signed({1'b0, tch_pkg::atan_tab(k)});
      end else begin
        px_d[k+1] = px_q[k] + (py_q[k] >>> k);
        py_d[k+1] = py_q[k] - (px_q[k] >>> k);
        pz_d[k+1] = pz_q[k] + $signed({1'b0, tch_pkg::atan_tab(k)});
      end
      rf_d[k+1] = rf_q[k];
      pf_d[k+1] = pf_q[k];
      xx_d[k+1] = xx_q[k];
      yy_d[k+1] = yy_q[k];
      zz_d[k+1] = zz_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= N; k++) begin
        rx_q[k] <= rx_d[k];
        ry_q[k] <= ry_d[k];
        rz_q[k] <= rz_d[k];
        px_q[k] <= px_d[k];
        py_q[k] <= py_d[k];
        pz_q[k] <= pz_d[k];
        rf_q[k] <= rf_d[k];
        pf_q[k] <= pf_d[k];
        xx_q[k] <= xx_d[k];
        yy_q[k] <= yy_d[k];
        zz_q[k] <= zz_d[k];
      end
    end
  end

  // quadrant fix and cut to Q16
  logic signed [tch_pkg::SC_W-1:0]   rxf, ryf, pxf, pyf;
  logic signed [tch_pkg::TRIG_W-1:0] cr_q, sr_q, cp_q, sp_q;
  logic signed [tch_pkg::DIFF_W-1:0] qxx_q, qyy_q, qzz_q;

  always_comb begin
    rxf = rf_q[N] ? -rx_q[N] : rx_q[N];
    ryf = rf_q[N] ? -ry_q[N] : ry_q[N];
    pxf = pf_q[N] ? -px_q[N] : px_q[N];
    pyf = pf_q[N] ? -py_q[N] : py_q[N];
  end

  // tilt rotation stages
  logic signed [tch_pkg::PROD_W-1:0] p_cy_q, p_sz_q, p_sy_q, p_cz_q, cpxx_q;
  logic signed [tch_pkg::TRIG_W-1:0] m1_sp_q, m2_sp_q;
  logic signed [tch_pkg::SUM_W-1:0]  hy_q, w_q, m3_hy_q, m4_hy_q;
  logic signed [tch_pkg::PROD_W-1:0] m2_cpxx_q, m3_cpxx_q, m4_cpxx_q;
  logic signed [tch_pkg::PROD_W:0]   pl_q;
  logic signed [tch_pkg::PROD_W-1:0] ph_q;
  logic signed [tch_pkg::SPW_W-1:0]  spw_q;
  logic signed [tch_pkg::VEC_W-1:0]  hx_q, vy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cr_q  <= rxf[tch_pkg::SC_W-1:14];
      sr_q  <= ryf[tch_pkg::SC_W-1:14];
      cp_q  <= pxf[tch_pkg::SC_W-1:14];
      sp_q  <= pyf[tch_pkg::SC_W-1:14];
      qxx_q <= xx_q[N];
      qyy_q <= yy_q[N];
      qzz_q <= zz_q[N];

      p_cy_q  <= cr_q * qyy_q;
      p_sz_q  <= sr_q * qzz_q;
      p_sy_q  <= sr_q * qyy_q;
      p_cz_q  <= cr_q * qzz_q;
      cpxx_q  <= cp_q * qxx_q;
      m1_sp_q <= sp_q;

      hy_q      <= tch_pkg::SUM_W'(p_cy_q) - tch_pkg::SUM_W'(p_sz_q);
      w_q       <= tch_pkg::SUM_W'(p_sy_q) + tch_pkg::SUM_W'(p_cz_q);
      m2_sp_q   <= m1_sp_q;
      m2_cpxx_q <= cpxx_q;

      pl_q      <= m2_sp_q * $signed({1'b0, w_q[tch_pkg::WL_W-1:0]});
      ph_q      <= m2_sp_q * $signed(w_q[tch_pkg::SUM_W-1:tch_pkg::WL_W]);
      m3_hy_q   <= hy_q;
      m3_cpxx_q <= m2_cpxx_q;

      spw_q     <= (tch_pkg::SPW_W'(ph_q) <<< tch_pkg::WL_W) + tch_pkg::SPW_W'(pl_q);
      m4_hy_q   <= m3_hy_q;
      m4_cpxx_q <= m3_cpxx_q;

      hx_q <= (tch_pkg::VEC_W'(m4_cpxx_q) <<< 16) + tch_pkg::VEC_W'(spw_q);
      vy_q <= -(tch_pkg::VEC_W'(m4_hy_q) <<< 16);
    end
  end

  // atan2 vectoring stages
  logic signed [tch_pkg::VEC_W-1:0] vx_q [N+1], vyv_q [N+1], vx_d [N+1], vyv_d [N+1];
  logic [31:0]                      vz_q [N+1], vz_d [N+1];
  logic                             zf_q [N+1], zf_d [N+1];

  always_comb begin
    zf_d[0] = (hx_q == '0) && (vy_q == '0);
    if (hx_q[tch_pkg::VEC_W-1]) begin
      vx_d[0]  = -hx_q;
      vyv_d[0] = -vy_q;
      vz_d[0]  = tch_pkg::HALF_TURN;
    end else begin
      vx_d[0]  = hx_q;
      vyv_d[0] = vy_q;
      vz_d[0]  = '0;
    end
    for (int k = 0; k < N; k++) begin
      if (!vyv_q[k][tch_pkg::VEC_W-1]) begin
        vx_d[k+1]  = vx_q[k] + (vyv_q[k] >>> k);
        vyv_d[k+1] = vyv_q[k] - (vx_q[k] >>> k);
        vz_d[k+1]  = vz_q[k] + tch_pkg::atan_tab(k);
      end else begin
        vx_d[k+1]  = vx_q[k] - (vyv_q[k] >>> k);
        vyv_d[k+1] = vyv_q[k] + (vx_q[k] >>> k);
        vz_d[k+1]  = vz_q[k] - tch_pkg::atan_tab(k);
      end
      zf_d[k+1] = zf_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= N; k++) begin
        vx_q[k]  <= vx_d[k];
        vyv_q[k] <= vyv_d[k];
        vz_q[k]  <= vz_d[k];
        zf_q[k]  <= zf_d[k];
      end
    end
  end

  logic [31:0] t_sum;
  logic signed [tch_pkg::ANG_W-1:0] heading_q;

  assign t_sum = (zf_q[N] ? 32'h0 : vz_q[N]) + tch_pkg::HEADING_BIAS;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      heading_q <= $signed(t_sum[31:16]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], item_valid_i};
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign heading_o   = heading_q;

endmodule

// ===== hw/rtl/tilt_compensated_heading_top.sv =====
// Top level of the tilt-compensated heading block.
//
//  channel  dir  handshake               payload
//  cfg      in   cfg_we_i                cfg_idx_i, cfg_wdata_i
//  in       in   in_valid_i/in_stall_o   field_x/y/z_i, roll/pitch_angle_i
//  out      out  out_valid_o/out_stall_i heading_o
//
// One item per clock sustained while out_stall_i is low; the two CORDIC
// pipelines in the back end account for most of the latency.
// Reset is asynchronous, active low; offsets return to their defaults.
// An output stall while out_valid_o is high freezes the back pipeline;
// the 4-entry queue keeps accepting until full, then in_stall_o rises.
`timescale 1ns / 1ps
`include "tilt_compensated_heading_top_defines.svh"
module tilt_compensated_heading_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tch_pkg::IDX_W-1:0]           cfg_idx_i,
  input  logic [tch_pkg::FIELD_W-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [tch_pkg::FIELD_W-1:0]  field_x_i,
  input  logic signed [tch_pkg::FIELD_W-1:0]  field_y_i,
  input  logic signed [tch_pkg::FIELD_W-1:0]  field_z_i,
  input  logic signed [tch_pkg::ANG_W-1:0]    roll_angle_i,
  input  logic signed [tch_pkg::ANG_W-1:0]    pitch_angle_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tch_pkg::ANG_W-1:0]    heading_o
);

  tch_pkg::item_t      front_item, fifo_item;
  tch_pkg::fifo_stat_t fifo_stat;
  logic                push, pop;

  tch_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .field_x_i     (field_x_i),
    .field_y_i     (field_y_i),
    .field_z_i     (field_z_i),
    .roll_angle_i  (roll_angle_i),
    .pitch_angle_i (pitch_angle_i),
    .in_stall_o    (in_stall_o),
    .fifo_full_i   (fifo_stat.full),
    .push_o        (push),
    .item_o        (front_item)
  );

  tch_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (fifo_item),
    .stat_o (fifo_stat)
  );

  tch_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (fifo_item),
    .item_valid_i (!fifo_stat.empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .heading_o    (heading_o)
  );

  `TCH_ASSERT_NOW(a_fifo_bound, 1'b1, fifo_stat.count <= tch_pkg::CNT_W'(tch_pkg::FIFO_DEPTH))
  `TCH_ASSERT_NOW(a_drain, !fifo_stat.empty && !(out_valid_o && out_stall_i), pop)
  `TCH_ASSERT_NEXT(a_count_hold, !push && !pop, $stable(fifo_stat.count))

endmodule

// ===== tb/tb_tilt_compensated_heading_top.sv =====
// Testbench for the tilt-compensated heading block: directed and random samples checked against a predictor.
`timescale 1ns / 1ps

class heading_scoreboard;
  bit signed [17:0] off_x, off_y, off_z;
  logic [15:0] expected_headings[$];
  int errors;

  function new();
    off_x = 18'sd2525;
    off_y = 18'sd2889;
    off_z = -18'sd1113;
    errors = 0;
  endfunction

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void sin_cos(logic [15:0] ang, output longint s, output longint c);
    logic [15:0] u;
    bit flip;
    longint x, y, z, nx, ny;
    u = ang;
    flip = ((u + 16'h4000) & 16'h8000) != 0;
    x = 652032874;
    y = 0;
    if (flip) u = u ^ 16'h8000;
    z = longint'($signed(u)) * 65536;
    for (int i = 0; i < tch_pkg::CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - shr(y, i);
        ny = y + shr(x, i);
        z = z - longint'(tch_pkg::atan_tab(i));
      end else begin
        nx = x + shr(y, i);
        ny = y - shr(x, i);
        z = z + longint'(tch_pkg::atan_tab(i));
      end
      x = nx;
      y = ny;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = shr(x, 14);
    s = shr(y, 14);
  endfunction

  function automatic logic [31:0] vector_angle(longint yv, longint xv);
    logic [31:0] z;
    longint x, y, nx, ny;
    z = 0;
    x = xv;
    y = yv;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < tch_pkg::CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + shr(y, i);
        ny = y - shr(x, i);
        z = z + tch_pkg::atan_tab(i);
      end else begin
        nx = x - shr(y, i);
        ny = y + shr(x, i);
        z = z - tch_pkg::atan_tab(i);
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function void write_offset(logic [1:0] idx, logic [17:0] val);
    if (idx == tch_pkg::REG_OFFSET_X) off_x = val;
    else if (idx == tch_pkg::REG_OFFSET_Y) off_y = val;
    else if (idx == tch_pkg::REG_OFFSET_Z) off_z = val;
  endfunction

  function void note_sample(logic signed [17:0] fx, fy, fz, logic [15:0] roll, pitch);
    longint xx, yy, zz, sr, cr, sp, cp, hy, w, hx;
    logic [31:0] t;
    xx = longint'(fx) - longint'(off_x);
    yy = longint'(fy) - longint'(off_y);
    zz = longint'(fz) - longint'(off_z);
    sin_cos(roll, sr, cr);
    sin_cos(pitch, sp, cp);
    hy = cr * yy - sr * zz;
    w = sr * yy + cr * zz;
    hx = cp * xx * 65536 + sp * w;
    hy = hy * 65536;
    t = vector_angle(-hy, hx) + tch_pkg::HEADING_BIAS;
    expected_headings.push_back(t[31:16]);
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_heading(logic [15:0] got);
    logic [15:0] want;
    if (expected_headings.size() == 0) begin
      report($sformatf("unexpected heading %0d", $signed(got)));
    end else begin
      want = expected_headings.pop_front();
      if (got !== want)
        report($sformatf("heading got %0d want %0d", $signed(got), $signed(want)));
    end
  endtask
endclass

module tb_tilt_compensated_heading_top;

  localparam int LATENCY = 1 + 2 * tch_pkg::CORDIC_STEPS + 9;
  localparam int LIMIT = 400000;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [tch_pkg::IDX_W-1:0] cfg_idx_i;
  logic [tch_pkg::FIELD_W-1:0] cfg_wdata_i;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic signed [tch_pkg::FIELD_W-1:0] field_x_i, field_y_i, field_z_i;
  logic signed [tch_pkg::ANG_W-1:0] roll_angle_i, pitch_angle_i, heading_o;

  heading_scoreboard sb;
  int cycles;
  int stall_mode;

  tilt_compensated_heading_top dut (.*);

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_sample(field_x_i, field_y_i, field_z_i, roll_angle_i, pitch_angle_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_heading(heading_o);
  end

  // receiver stall pattern, switching style every so often
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ((cycles % 16) < 11);
    endcase
  end

  task send_sample(logic signed [17:0] fx, fy, fz, logic [15:0] roll, pitch);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    field_x_i <= fx;
    field_y_i <= fy;
    field_z_i <= fz;
    roll_angle_i <= roll;
    pitch_angle_i <= pitch;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task pause_sender();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task write_offset(logic [1:0] idx, logic [17:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    sb.write_offset(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task drain();
    pause_sender();
    while (sb.expected_headings.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task random_burst(int n);
    int k;
    k = 0;
    while (k < n) begin
      for (int b = $urandom_range(1, 20); b > 0 && k < n; b--) begin
        send_sample(18'($urandom), 18'($urandom), 18'($urandom),
                    16'($urandom), 16'($urandom));
        k++;
      end
      if ($urandom_range(0, 2) != 0) begin
        pause_sender();
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    logic [15:0] angs[8];
    sb = new();
    cycles = 0;
    stall_mode = 0;
    cfg_we_i = 0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 0;
    out_stall_i = 0;
    field_x_i = '0;
    field_y_i = '0;
    field_z_i = '0;
    roll_angle_i = '0;
    pitch_angle_i = '0;
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    angs = '{16'h0000, 16'h4000, 16'hC000, 16'h8000, 16'h7FFF, 16'h3FFF, 16'hBFFF, 16'h2000};
    // extremes, quadrant edges, zero horizontal vector at reset offsets
    send_sample(18'sd2525, 18'sd2889, -18'sd1113, 16'h0000, 16'h0000);
    send_sample(18'sd2525, 18'sd2889, 18'sd9000, 16'h0000, 16'h0000);
    send_sample(-18'sd1000, 18'sd2889, -18'sd1113, 16'h0000, 16'h0000);
    foreach (angs[i])
      send_sample(18'h1FFFF, 18'h20000, 18'h1FFFF, angs[i], angs[7 - i]);
    send_sample(18'h20000, 18'h1FFFF, 18'h20000, 16'h8000, 16'h8000);
    send_sample(18'h3FFFF, 18'h00000, 18'h3FFFF, 16'hFFFF, 16'h0001);
    drain();

    // extreme offsets, full-width subtraction
    write_offset(tch_pkg::REG_OFFSET_X, 18'h1FFFF);
    write_offset(tch_pkg::REG_OFFSET_Y, 18'h20000);
    write_offset(tch_pkg::REG_OFFSET_Z, 18'h1FFFF);
    write_offset(2'd3, 18'h12345);
    send_sample(18'h20000, 18'h1FFFF, 18'h20000, 16'h0000, 16'h0000);
    send_sample(18'h20000, 18'h1FFFF, 18'h20000, 16'h4000, 16'hC000);
    random_burst(200);
    drain();

    write_offset(tch_pkg::REG_OFFSET_X, 18'h20000);
    write_offset(tch_pkg::REG_OFFSET_Y, 18'h1FFFF);
    write_offset(tch_pkg::REG_OFFSET_Z, 18'h20000);
    random_burst(200);
    drain();

    write_offset(tch_pkg::REG_OFFSET_X, 18'h0);
    write_offset(tch_pkg::REG_OFFSET_Y, 18'h0);
    write_offset(tch_pkg::REG_OFFSET_Z, 18'h0);
    send_sample(18'h0, 18'h0, 18'h0, 16'h1234, 16'h4321);
    random_burst(200);
    drain();

    write_offset(tch_pkg::REG_OFFSET_X, 18'($urandom));
    write_offset(tch_pkg::REG_OFFSET_Y, 18'($urandom));
    write_offset(tch_pkg::REG_OFFSET_Z, 18'($urandom));
    random_burst(230);
    drain();

    if (sb.errors == 0 && sb.expected_headings.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
